### hw/rtl/udrb_pkg.sv
// Shared command codes and result beat layout for the dual serial byte ring buffer.
`timescale 1ns / 1ps
`default_nettype none
package udrb_pkg;

	localparam int unsigned CMD_W = 3;

	localparam logic [CMD_W-1:0] CMD_PUSH_TX  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP_RX   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TX_READY = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RX_BYTE  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DISABLE  = 3'd4;

	localparam int unsigned IN_DATA_W  = 16;
	localparam int unsigned OUT_DATA_W = 32;
	localparam int unsigned COUNT_W    = 6;

	// Result beat, first member in the highest bits.
	typedef struct packed {
		logic [4:0]         pad;
		logic               overflow;
		logic               cli_active;
		logic               tx_irq_enabled;
		logic [COUNT_W-1:0] rx_count;
		logic               line_valid;
		logic [7:0]         line_byte;
		logic               read_valid;
		logic [7:0]         read_byte;
	} out_beat_t;

endpackage
`default_nettype wire

### hw/rtl/uart_dual_ring_buffer.sv
// Top level of the dual transmit and receive byte ring buffer.
`timescale 1ns / 1ps
`default_nettype none
// Each input beat is one event: a transmit push, a receive pop, a transmitter-ready event, a
// received byte or a disable command. Its result beat goes through the s1 register stage and then
// the output register, and no new input beat is taken while one is still in the s1 stage: the ring
// positions and flags update as the beat is taken, and the byte stores are synchronous
// memories whose read data is registered, so a popped byte is only known in the cycle after.
// The input side is held off while an event is in the s1 stage or while the output
// register holds a result that is not being taken. The stores need no clearing after reset,
// as only written entries are ever read; the block takes beats from the first cycle after reset.
module uart_dual_ring_buffer #(
	parameter int unsigned RX_DEPTH = 64,
	parameter int unsigned TX_DEPTH = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output      logic                                s_tready,
	// data_byte [7:0], disable_receive [8], zero [15:9]
	input  wire logic [udrb_pkg::IN_DATA_W-1:0]      s_tdata,
	// command [2:0]
	input  wire logic [udrb_pkg::CMD_W-1:0]          s_tuser,
	input  wire logic                                s_tlast,
	output      logic                                m_tvalid,
	input  wire logic                                m_tready,
	// read_byte [7:0], read_valid [8], line_byte [16:9], line_valid [17], rx_count [23:18],
	// tx_irq_enabled [24], cli_active [25], overflow [26], zero [31:27]
	output      logic [udrb_pkg::OUT_DATA_W-1:0]     m_tdata
);

	localparam int unsigned RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
	localparam int unsigned TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
	localparam int unsigned CNT_W = RX_AW + 1;

	logic [7:0] rx_mem [RX_DEPTH];
	logic [7:0] tx_mem [TX_DEPTH];

	logic [RX_AW-1:0] rx_head_q, rx_tail_q, rx_head_d, rx_tail_d, rx_head_nx, rx_tail_nx;
	logic [TX_AW-1:0] tx_head_q, tx_tail_q, tx_head_d, tx_tail_d, tx_head_nx, tx_tail_nx;
	logic             tx_en_q, tx_en_d, active_q, active_d, rx_on_q, rx_on_d;

	logic       s_accept;
	logic [7:0] in_byte;
	logic       in_dis_rx;
	logic       tx_we, tx_re, rx_we, rx_re, ovf_d;

	logic [7:0] rx_rdata_q, tx_rdata_q;
	logic       valid_s1, rd_s1, ln_s1, ovf_s1, tx_en_s1, active_s1;
	logic [udrb_pkg::COUNT_W-1:0] count_s1;

	logic [CNT_W-1:0]                   fill;
	logic [CNT_W+udrb_pkg::COUNT_W-1:0] fill_ext;

	udrb_pkg::out_beat_t out_q;

	assign in_byte   = s_tdata[7:0];
	assign in_dis_rx = s_tdata[8];
	assign s_tready  = !valid_s1 && (!m_tvalid || m_tready);
	assign s_accept  = s_tvalid && s_tready;

	assign rx_head_nx = (rx_head_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_q + 1'b1;
	assign rx_tail_nx = (rx_tail_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail_q + 1'b1;
	assign tx_head_nx = (tx_head_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_q + 1'b1;
	assign tx_tail_nx = (tx_tail_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail_q + 1'b1;

	always_comb begin
		rx_head_d = rx_head_q;
		rx_tail_d = rx_tail_q;
		tx_head_d = tx_head_q;
		tx_tail_d = tx_tail_q;
		tx_en_d   = tx_en_q;
		active_d  = active_q;
		rx_on_d   = rx_on_q;
		tx_we     = 1'b0;
		tx_re     = 1'b0;
		rx_we     = 1'b0;
		rx_re     = 1'b0;
		ovf_d     = 1'b0;
		unique case (s_tuser)
			udrb_pkg::CMD_PUSH_TX: begin
				if (tx_head_nx == tx_tail_q) begin
					ovf_d = 1'b1;
				end else begin
					tx_we     = 1'b1;
					tx_head_d = tx_head_nx;
				end
				if (s_tlast) begin
					tx_en_d = 1'b1;
				end
			end
			udrb_pkg::CMD_POP_RX: begin
				if (rx_tail_q != rx_head_q) begin
					rx_re     = 1'b1;
					rx_tail_d = rx_tail_nx;
				end
			end
			udrb_pkg::CMD_TX_READY: begin
				if (tx_tail_q != tx_head_q) begin
					tx_re     = 1'b1;
					tx_tail_d = tx_tail_nx;
				end else begin
					tx_en_d = 1'b0;
				end
			end
			udrb_pkg::CMD_RX_BYTE: begin
				if (rx_on_q) begin
					active_d = 1'b1;
					if (rx_head_nx == rx_tail_q) begin
						ovf_d = 1'b1;
					end else begin
						rx_we     = 1'b1;
						rx_head_d = rx_head_nx;
					end
				end
			end
			udrb_pkg::CMD_DISABLE: begin
				if (in_dis_rx) begin
					rx_on_d = 1'b0;
				end
				active_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (rx_head_d >= rx_tail_d) begin
			fill = CNT_W'(rx_head_d) - CNT_W'(rx_tail_d);
		end else begin
			fill = CNT_W'(rx_head_d) + CNT_W'(RX_DEPTH) - CNT_W'(rx_tail_d);
		end
		fill_ext = {{udrb_pkg::COUNT_W{1'b0}}, fill};
	end

	always_ff @(posedge clk) begin
		if (s_accept && rx_we) begin
			rx_mem[rx_head_q] <= in_byte;
		end
		if (s_accept && rx_re) begin
			rx_rdata_q <= rx_mem[rx_tail_q];
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept && tx_we) begin
			tx_mem[tx_head_q] <= in_byte;
		end
		if (s_accept && tx_re) begin
			tx_rdata_q <= tx_mem[tx_tail_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q <= '0;
			rx_tail_q <= '0;
			tx_head_q <= '0;
			tx_tail_q <= '0;
			tx_en_q   <= 1'b0;
			active_q  <= 1'b0;
			rx_on_q   <= 1'b1;
			valid_s1  <= 1'b0;
			m_tvalid  <= 1'b0;
		end else begin
			if (s_accept) begin
				rx_head_q <= rx_head_d;
				rx_tail_q <= rx_tail_d;
				tx_head_q <= tx_head_d;
				tx_tail_q <= tx_tail_d;
				tx_en_q   <= tx_en_d;
				active_q  <= active_d;
				rx_on_q   <= rx_on_d;
			end
			valid_s1 <= s_accept;
			if (valid_s1) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			rd_s1     <= rx_re;
			ln_s1     <= tx_re;
			ovf_s1    <= ovf_d;
			tx_en_s1  <= tx_en_d;
			active_s1 <= active_d;
			count_s1  <= fill_ext[udrb_pkg::COUNT_W-1:0];
		end
		if (valid_s1) begin
			out_q.pad            <= '0;
			out_q.overflow       <= ovf_s1;
			out_q.cli_active     <= active_s1;
			out_q.tx_irq_enabled <= tx_en_s1;
			out_q.rx_count       <= count_s1;
			out_q.line_valid     <= ln_s1;
			out_q.line_byte      <= ln_s1 ? tx_rdata_q : 8'd0;
			out_q.read_valid     <= rd_s1;
			out_q.read_byte      <= rd_s1 ? rx_rdata_q : 8'd0;
		end
	end

	assign m_tdata = out_q;

endmodule
`default_nettype wire

### hw/rtl/udrb_checker.sv
// Port-level checks on the dual ring buffer, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
module udrb_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic [udrb_pkg::CMD_W-1:0]      s_tuser,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [udrb_pkg::OUT_DATA_W-1:0] m_tdata
);

	udrb_pkg::out_beat_t beat;
	assign beat = m_tdata;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Result beat withdrawn before it was taken.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Input beat taken while the previous one was still at work.");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !beat.read_valid |-> beat.read_byte == 8'd0)
		else $error("Receive byte not zero without a popped byte.");

	a_line_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !beat.line_valid |-> beat.line_byte == 8'd0)
		else $error("Line byte not zero without a byte to send.");

	a_pop_no_flags: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == udrb_pkg::CMD_POP_RX
		|=> ##1 !beat.overflow && !beat.line_valid)
		else $error("Receive pop reported an overflow or a line byte.");

endmodule

bind uart_dual_ring_buffer udrb_checker u_udrb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

### tb/uart_dual_ring_buffer_tb.sv
// Self-checking testbench for the dual transmit and receive byte ring buffer.
`timescale 1ns / 1ps
module uart_dual_ring_buffer_tb;

	localparam logic [udrb_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd5;
	localparam logic [udrb_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	typedef struct {
		logic [udrb_pkg::CMD_W-1:0] cmd;
		logic [7:0]                 data;
		bit                         last;
		bit                         rx_off;
		bit                         all_zero;
	} event_row_t;

	typedef enum int unsigned {MIX_TX_FILL, MIX_RX_FILL, MIX_DRAIN, MIX_ANY} mix_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [udrb_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic [udrb_pkg::CMD_W-1:0]      s_tuser = '0;
	logic                            s_tlast = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [udrb_pkg::OUT_DATA_W-1:0] m_tdata;

	// Predicted state of both rings and the flags.
	logic [7:0]   rx_mem [64];
	logic [7:0]   tx_mem [64];
	logic [5:0]   rx_wr = '0;
	logic [5:0]   rx_rd = '0;
	logic [5:0]   tx_wr = '0;
	logic [5:0]   tx_rd = '0;
	bit           tx_irq = 1'b0;
	bit           cli = 1'b0;
	bit           rx_on = 1'b1;

	udrb_pkg::out_beat_t pending_status [$];
	event_row_t   opening [$];
	event_row_t   closing [$];
	int unsigned  cmd_seen [8];
	int unsigned  drops = 0;
	int unsigned  fill_peak = 0;
	int unsigned  beats_checked = 0;
	int unsigned  fault_count = 0;
	int unsigned  src_idle_pct = 0;
	int unsigned  sink_idle_pct = 0;
	int unsigned  stall_cycles = 0;

	uart_dual_ring_buffer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic udrb_pkg::out_beat_t next_status(logic [udrb_pkg::CMD_W-1:0] cmd,
			logic [7:0] data, bit last, bit rx_off);
		udrb_pkg::out_beat_t r;
		logic [5:0] nx;
		r = '0;
		cmd_seen[cmd]++;
		case (cmd)
		udrb_pkg::CMD_PUSH_TX: begin
			nx = tx_wr + 6'd1;
			if (nx == tx_rd) begin
				r.overflow = 1'b1;
				drops++;
			end else begin
				tx_mem[tx_wr] = data;
				tx_wr = nx;
			end
			if (last) tx_irq = 1'b1;
		end
		udrb_pkg::CMD_POP_RX: begin
			if (rx_rd != rx_wr) begin
				r.read_byte = rx_mem[rx_rd];
				r.read_valid = 1'b1;
				rx_rd = rx_rd + 6'd1;
			end
		end
		udrb_pkg::CMD_TX_READY: begin
			if (tx_rd != tx_wr) begin
				r.line_byte = tx_mem[tx_rd];
				r.line_valid = 1'b1;
				tx_rd = tx_rd + 6'd1;
			end else begin
				tx_irq = 1'b0;
			end
		end
		udrb_pkg::CMD_RX_BYTE: begin
			if (rx_on) begin
				nx = rx_wr + 6'd1;
				cli = 1'b1;
				if (nx == rx_rd) begin
					r.overflow = 1'b1;
					drops++;
				end else begin
					rx_mem[rx_wr] = data;
					rx_wr = nx;
				end
			end
		end
		udrb_pkg::CMD_DISABLE: begin
			if (rx_off) rx_on = 1'b0;
			cli = 1'b0;
		end
		default: ;
		endcase
		r.rx_count = rx_wr - rx_rd;
		r.tx_irq_enabled = tx_irq;
		r.cli_active = cli;
		if (r.rx_count > fill_peak) fill_peak = r.rx_count;
		return r;
	endfunction

	function automatic string show(udrb_pkg::out_beat_t b);
		return $sformatf("rd %02h/%0d line %02h/%0d count %0d irq %0d cli %0d ovf %0d",
			b.read_byte, b.read_valid, b.line_byte, b.line_valid, b.rx_count,
			b.tx_irq_enabled, b.cli_active, b.overflow);
	endfunction

	task automatic note_fault(string what);
		fault_count++;
		if (fault_count <= 10) $display("%s", what);
	endtask

	task automatic check_beat(udrb_pkg::out_beat_t got);
		udrb_pkg::out_beat_t want;
		if (pending_status.size() == 0) begin
			note_fault($sformatf("Unexpected status beat: %s", show(got)));
		end else begin
			want = pending_status.pop_front();
			if (got.read_byte !== want.read_byte || got.read_valid !== want.read_valid ||
					got.line_byte !== want.line_byte || got.line_valid !== want.line_valid ||
					got.rx_count !== want.rx_count ||
					got.tx_irq_enabled !== want.tx_irq_enabled ||
					got.cli_active !== want.cli_active || got.overflow !== want.overflow)
				note_fault($sformatf("Beat %0d expected %s, got %s", beats_checked,
					show(want), show(got)));
		end
		beats_checked++;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) check_beat(udrb_pkg::out_beat_t'(m_tdata));
	end

	initial begin
		int unsigned hold;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_cycles != 0) begin
				hold = stall_cycles;
				stall_cycles = 0;
				m_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	function automatic event_row_t mk(logic [udrb_pkg::CMD_W-1:0] cmd, logic [7:0] data,
			bit last, bit rx_off, bit all_zero);
		event_row_t e;
		e.cmd = cmd;
		e.data = data;
		e.last = last;
		e.rx_off = rx_off;
		e.all_zero = all_zero;
		return e;
	endfunction

	task automatic send_beat(event_row_t e);
		udrb_pkg::out_beat_t want;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= e.cmd;
		s_tdata <= {{(udrb_pkg::IN_DATA_W-9){1'b0}}, e.rx_off, e.data};
		s_tlast <= e.last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		want = next_status(e.cmd, e.data, e.last, e.rx_off);
		pending_status.push_back(e.all_zero ? udrb_pkg::out_beat_t'('0) : want);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
	endtask

	function automatic logic [udrb_pkg::CMD_W-1:0] pick_cmd(mix_t mix);
		int unsigned p;
		p = $urandom_range(99);
		case (mix)
		MIX_TX_FILL:
			return p < 70 ? udrb_pkg::CMD_PUSH_TX : p < 85 ? udrb_pkg::CMD_TX_READY :
				p < 95 ? udrb_pkg::CMD_RX_BYTE : udrb_pkg::CMD_POP_RX;
		MIX_RX_FILL:
			return p < 70 ? udrb_pkg::CMD_RX_BYTE : p < 85 ? udrb_pkg::CMD_POP_RX :
				p < 92 ? udrb_pkg::CMD_PUSH_TX : p < 96 ? udrb_pkg::CMD_DISABLE :
				udrb_pkg::CMD_TX_READY;
		MIX_DRAIN:
			return p < 40 ? udrb_pkg::CMD_TX_READY : p < 80 ? udrb_pkg::CMD_POP_RX :
				p < 90 ? udrb_pkg::CMD_PUSH_TX : p < 97 ? udrb_pkg::CMD_RX_BYTE :
				udrb_pkg::CMD_DISABLE;
		default:
			return p < 25 ? udrb_pkg::CMD_PUSH_TX : p < 45 ? udrb_pkg::CMD_POP_RX :
				p < 65 ? udrb_pkg::CMD_TX_READY : p < 85 ? udrb_pkg::CMD_RX_BYTE :
				p < 93 ? udrb_pkg::CMD_DISABLE :
				udrb_pkg::CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
		endcase
	endfunction

	// Runs of biased traffic fill one ring past full, drain both or mix every command, spare
	// codes included, so overflow and empty-ring cases recur; receive is never switched off here.
	task automatic run_random(int unsigned count);
		mix_t mix;
		int unsigned left;
		int unsigned n;
		logic [udrb_pkg::CMD_W-1:0] cmd;
		n = 0;
		while (n < count) begin
			mix = mix_t'($urandom_range(3));
			left = $urandom_range(90, 30);
			while (left != 0 && n < count) begin
				cmd = pick_cmd(mix);
				send_beat(mk(cmd, 8'($urandom_range(255)), $urandom_range(7) == 0,
					cmd != udrb_pkg::CMD_DISABLE && $urandom_range(1) == 1, 1'b0));
				left--;
				n++;
			end
		end
	endtask

	initial begin
		#10_000_000;
		$display("uart_dual_ring_buffer: mismatch");
		$finish;
	end

	initial begin
		opening.push_back(mk(udrb_pkg::CMD_POP_RX,   8'h00, 1'b0, 1'b0, 1'b1));
		opening.push_back(mk(udrb_pkg::CMD_TX_READY, 8'hFF, 1'b1, 1'b1, 1'b1));
		opening.push_back(mk(CMD_SPARE_LO,           8'hFF, 1'b1, 1'b1, 1'b1));
		opening.push_back(mk(CMD_SPARE_HI,           8'h00, 1'b0, 1'b0, 1'b1));
		opening.push_back(mk(udrb_pkg::CMD_DISABLE,  8'hFF, 1'b1, 1'b0, 1'b1));
		opening.push_back(mk(udrb_pkg::CMD_PUSH_TX,  8'h00, 1'b0, 1'b1, 1'b1));
		opening.push_back(mk(udrb_pkg::CMD_PUSH_TX,  8'hFF, 1'b1, 1'b0, 1'b0));
		opening.push_back(mk(udrb_pkg::CMD_PUSH_TX,  8'h5A, 1'b0, 1'b1, 1'b0));
		opening.push_back(mk(udrb_pkg::CMD_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0));
		opening.push_back(mk(udrb_pkg::CMD_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0));
		opening.push_back(mk(udrb_pkg::CMD_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0));
		opening.push_back(mk(udrb_pkg::CMD_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0));
		opening.push_back(mk(udrb_pkg::CMD_RX_BYTE,  8'hFF, 1'b1, 1'b1, 1'b0));
		opening.push_back(mk(udrb_pkg::CMD_RX_BYTE,  8'h00, 1'b0, 1'b0, 1'b0));
		opening.push_back(mk(udrb_pkg::CMD_RX_BYTE,  8'hA5, 1'b0, 1'b0, 1'b0));
		opening.push_back(mk(udrb_pkg::CMD_DISABLE,  8'h00, 1'b0, 1'b0, 1'b0));
		opening.push_back(mk(udrb_pkg::CMD_POP_RX,   8'hFF, 1'b1, 1'b1, 1'b0));
		opening.push_back(mk(udrb_pkg::CMD_POP_RX,   8'h00, 1'b0, 1'b0, 1'b0));
		opening.push_back(mk(udrb_pkg::CMD_POP_RX,   8'h00, 1'b0, 1'b0, 1'b0));
		opening.push_back(mk(udrb_pkg::CMD_POP_RX,   8'h00, 1'b0, 1'b0, 1'b0));
		opening.push_back(mk(udrb_pkg::CMD_RX_BYTE,  8'h81, 1'b1, 1'b0, 1'b0));
		closing.push_back(mk(udrb_pkg::CMD_DISABLE,  8'h00, 1'b0, 1'b1, 1'b0));
		closing.push_back(mk(udrb_pkg::CMD_RX_BYTE,  8'h3C, 1'b0, 1'b0, 1'b0));
		closing.push_back(mk(udrb_pkg::CMD_POP_RX,   8'h00, 1'b0, 1'b0, 1'b0));
		closing.push_back(mk(udrb_pkg::CMD_PUSH_TX,  8'h96, 1'b1, 1'b0, 1'b0));
		closing.push_back(mk(udrb_pkg::CMD_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 20;
		sink_idle_pct = 85;
		foreach (opening[i]) send_beat(opening[i]);
		run_random(560);
		wait_drained();

		src_idle_pct = 85;
		sink_idle_pct = 20;
		run_random(560);
		wait_drained();

		// The output side is held off for a long stretch while the source keeps offering events.
		src_idle_pct = 0;
		sink_idle_pct = 0;
		stall_cycles = 400;
		run_random(580);
		wait_drained();

		foreach (closing[i]) send_beat(closing[i]);
		wait_drained();
		repeat (8) @(posedge clk);

		if (pending_status.size() != 0)
			note_fault($sformatf("%0d status beats never arrived", pending_status.size()));
		$display({"Checked %0d status beats: %0d pushes, %0d pops, %0d ready events, ",
			"%0d received bytes, %0d disables."},
			beats_checked, cmd_seen[udrb_pkg::CMD_PUSH_TX], cmd_seen[udrb_pkg::CMD_POP_RX],
			cmd_seen[udrb_pkg::CMD_TX_READY], cmd_seen[udrb_pkg::CMD_RX_BYTE],
			cmd_seen[udrb_pkg::CMD_DISABLE]);
		$display({"%0d writes were dropped on full rings, the receive ring peaked at %0d ",
			"bytes, and receive was switched off at the end."}, drops, fill_peak);
		if (fault_count == 0) begin
			$display("uart_dual_ring_buffer: match");
		end else begin
			$display("uart_dual_ring_buffer: mismatch");
		end
		$finish;
	end

endmodule
